// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define LOM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LOM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg
// Types and constants shared by the order matcher cells, control and top.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int ORDER_SLOTS = 64;
  localparam int SLOT_W      = $clog2(ORDER_SLOTS);
  // scan length: the registered command, then the chain of cells
  localparam int SCAN_CYCLES = ORDER_SLOTS + 1;
  localparam int CNT_W       = $clog2(SCAN_CYCLES + 1);
  localparam int MAX_TRADES  = 63;
  localparam int TRADE_W     = $clog2(MAX_TRADES + 1);

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_CANCEL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_DUP     = 3'd1,
    ST_MARKED  = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic {
    KIND_TRADE  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic               operation;
    logic [31:0]        order_id;
    logic               is_buy;
    logic signed [31:0] price;
    logic [30:0]        quantity;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         status;
    logic [31:0]        resting_id;
    logic [31:0]        taker_id;
    logic               aggressor_is_buy;
    logic signed [31:0] trade_price;
    logic [30:0]        trade_size;
    logic               last;
  } res_t;

  // best order seen so far on one side
  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  idx;
    logic signed [31:0] price;
    logic [63:0]        arrival;
    logic [30:0]        qty;
    logic [31:0]        id;
    logic               canceled;
  } best_t;

  // scan token passed from cell to cell
  typedef struct packed {
    logic              id_found;
    logic [SLOT_W-1:0] id_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    best_t             bid;
    best_t             ask;
  } tok_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic [31:0]        key_id;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_idx;
    logic [31:0]        wr_id;
    logic               wr_buy;
    logic signed [31:0] wr_price;
    logic [30:0]        wr_qty;
    logic [63:0]        wr_arrival;
    logic               cancel_en;
    logic [SLOT_W-1:0]  cancel_idx;
    logic               free_en;
    logic [SLOT_W-1:0]  free_idx;
    logic               fill_en;
    logic [SLOT_W-1:0]  bid_idx;
    logic [SLOT_W-1:0]  ask_idx;
    logic [30:0]        fill;
  } cmd_t;

endpackage

// File: hw/rtl/lom_cell.sv
// ----------------------------------------------------------------------------
// lom_cell
// One order slot: holds its order, folds itself into the passing scan token.
// ----------------------------------------------------------------------------
module lom_cell
  import lom_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] idx_i,
  input  cmd_t              cmd_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic               valid_q;
  logic               canceled_q;
  logic [31:0]        id_q;
  logic               buy_q;
  logic signed [31:0] price_q;
  logic [30:0]        qty_q;
  logic [63:0]        arr_q;
  tok_t               tok_d, tok_q;
  best_t              mine;
  logic               hit_fill;

  assign hit_fill = cmd_i.fill_en && ((cmd_i.bid_idx == idx_i) || (cmd_i.ask_idx == idx_i));

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en && cmd_i.wr_idx == idx_i) begin
        valid_q <= 1'b1;
      end else if (cmd_i.free_en && cmd_i.free_idx == idx_i) begin
        valid_q <= 1'b0;
      end else if (hit_fill && qty_q == cmd_i.fill) begin
        valid_q <= 1'b0;  // emptied
      end
    end
  end

  // order payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_idx == idx_i) begin
      id_q       <= cmd_i.wr_id;
      buy_q      <= cmd_i.wr_buy;
      price_q    <= cmd_i.wr_price;
      qty_q      <= cmd_i.wr_qty;
      arr_q      <= cmd_i.wr_arrival;
      canceled_q <= 1'b0;
    end else begin
      if (cmd_i.cancel_en && cmd_i.cancel_idx == idx_i) begin
        canceled_q <= 1'b1;
      end
      if (hit_fill) begin
        qty_q <= qty_q - cmd_i.fill;
      end
    end
  end

  assign mine = '{found: 1'b1, idx: idx_i, price: price_q, arrival: arr_q, qty: qty_q,
                  id: id_q, canceled: canceled_q};

  // fold this slot into the token; earlier slots win id and free ties, earlier arrival wins price ties
  always_comb begin
    tok_d = tok_i;
    if (valid_q && !tok_i.id_found && id_q == cmd_i.key_id) begin
      tok_d.id_found = 1'b1;
      tok_d.id_idx   = idx_i;
    end
    if (!valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = idx_i;
    end
    if (valid_q && buy_q && (!tok_i.bid.found || price_q > tok_i.bid.price ||
        (price_q == tok_i.bid.price && arr_q < tok_i.bid.arrival))) begin
      tok_d.bid = mine;
    end
    if (valid_q && !buy_q && (!tok_i.ask.found || price_q < tok_i.ask.price ||
        (price_q == tok_i.ask.price && arr_q < tok_i.ask.arrival))) begin
      tok_d.ask = mine;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_o = tok_q;

endmodule

// File: hw/rtl/lom_ctrl.sv
// ----------------------------------------------------------------------------
// lom_ctrl
// Sequencer: waits for full scans, decides lookups, adds, cancel marks, trades and frees.
// ----------------------------------------------------------------------------
module lom_ctrl
  import lom_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  input  tok_t tok_i,
  output cmd_t cmd_o,
  output res_t res_o,
  output logic res_valid_o
);

`include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_MATCH  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TRADE_W-1:0] trades_q, trades_d;
  logic [63:0]        arrival_q, arrival_d;
  req_t               req_q;
  cmd_t               cmd_q, cmd_d;
  res_t               res_q, res_d;
  logic               res_valid_q, res_valid_d;
  logic               scan_done, crossed, bid_rests, bid_aggr;
  logic [30:0]        fill;

  assign scan_done = (cnt_q == CNT_W'(SCAN_CYCLES));
  assign crossed   = tok_i.bid.found && tok_i.ask.found && !(tok_i.bid.price < tok_i.ask.price);
  assign bid_rests = tok_i.bid.arrival < tok_i.ask.arrival;
  assign bid_aggr  = tok_i.bid.arrival > tok_i.ask.arrival;
  assign fill      = (tok_i.bid.qty < tok_i.ask.qty) ? tok_i.bid.qty : tok_i.ask.qty;

  // decision logic
  always_comb begin
    state_d     = state_q;
    cnt_d       = scan_done ? cnt_q : cnt_q + CNT_W'(1);
    trades_d    = trades_q;
    arrival_d   = arrival_q;
    cmd_d       = '0;
    cmd_d.key_id = req_q.order_id;
    res_d       = res_q;
    res_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (start) begin
          cmd_d.key_id = req_i.order_id;
          state_d      = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (scan_done) begin
          res_d        = '0;
          res_d.kind   = KIND_STATUS;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
          if (req_q.operation == OP_CANCEL) begin
            res_valid_d = 1'b1;
            if (tok_i.id_found) begin
              cmd_d.cancel_en  = 1'b1;
              cmd_d.cancel_idx = tok_i.id_idx;
              res_d.status     = ST_MARKED;
            end else begin
              res_d.status = ST_UNKNOWN;
            end
          end else if (tok_i.id_found) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_DUP;
          end else if (!tok_i.free_found) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_FULL;
          end else begin
            cmd_d.wr_en      = 1'b1;
            cmd_d.wr_idx     = tok_i.free_idx;
            cmd_d.wr_id      = req_q.order_id;
            cmd_d.wr_buy     = req_q.is_buy;
            cmd_d.wr_price   = req_q.price;
            cmd_d.wr_qty     = req_q.quantity;
            cmd_d.wr_arrival = arrival_q;
            arrival_d        = arrival_q + 64'd1;
            trades_d         = '0;
            cnt_d            = '0;
            state_d          = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        if (scan_done) begin
          cnt_d = '0;
          if (trades_q == TRADE_W'(MAX_TRADES) || !crossed) begin
            res_d        = '0;
            res_d.kind   = KIND_STATUS;
            res_d.status = ST_ADDED;
            res_d.last   = 1'b1;
            res_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else if (tok_i.bid.canceled) begin
            cmd_d.free_en  = 1'b1;
            cmd_d.free_idx = tok_i.bid.idx;
          end else if (tok_i.ask.canceled) begin
            cmd_d.free_en  = 1'b1;
            cmd_d.free_idx = tok_i.ask.idx;
          end else begin
            cmd_d.fill_en          = 1'b1;
            cmd_d.bid_idx          = tok_i.bid.idx;
            cmd_d.ask_idx          = tok_i.ask.idx;
            cmd_d.fill             = fill;
            res_d                  = '0;
            res_d.kind             = KIND_TRADE;
            res_d.resting_id       = bid_rests ? tok_i.bid.id : tok_i.ask.id;
            res_d.taker_id         = bid_aggr ? tok_i.bid.id : tok_i.ask.id;
            res_d.aggressor_is_buy = bid_aggr;
            res_d.trade_price      = bid_rests ? tok_i.bid.price : tok_i.ask.price;
            res_d.trade_size       = fill;
            res_valid_d            = 1'b1;
            trades_d               = trades_q + TRADE_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      trades_q    <= '0;
      arrival_q   <= '0;
      res_valid_q <= 1'b0;
      cmd_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      trades_q    <= trades_d;
      arrival_q   <= arrival_d;
      res_valid_q <= res_valid_d;
      cmd_q       <= cmd_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cmd_o       = cmd_q;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  `LOM_ASSERT(a_last_ends_item, res_valid_o && res_o.last, !busy, "status item while still busy")
  `LOM_ASSERT(a_trade_not_last, res_valid_o && !res_o.last, busy, "trade item after item ended")
  `LOM_ASSERT_NEXT(a_start_busy, start && !busy, busy && !res_valid_o, "accepted item not taken")
  `LOM_ASSERT(a_one_update, cmd_o.wr_en, !cmd_o.fill_en && !cmd_o.free_en, "two updates at once")

endmodule

// File: hw/rtl/limit_order_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_matcher
// Limit order book with price-time priority matching over a chain of slots.
// ----------------------------------------------------------------------------
// One item (add or cancel) is taken while busy is low. Every lookup or
// matching round is one pass of a scan token down the chain of ORDER_SLOTS
// cells, one cell per cycle. A cancel or rejected add takes one lookup
// round; a stored add takes that plus one matching round for each trade
// or freed canceled order, and one final round. Results come one per
// strobe on res_valid_o (trades, then the status item with last set); the
// receiver cannot stall, so each is there for exactly one cycle and must
// be captured then.
// ----------------------------------------------------------------------------
module limit_order_matcher
  import lom_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output res_t res_o,
  output logic res_valid_o
);

  tok_t tok [ORDER_SLOTS+1];
  cmd_t cmd;

  assign tok[0] = '0;

  // chain of slot cells
  for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
    lom_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_W'(i)),
      .cmd_i  (cmd),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  lom_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .tok_i       (tok[ORDER_SLOTS]),
    .cmd_o       (cmd),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule
